FILE: design/scba_pkg.sv
// shared types and constants of the size class block allocator
package scba_pkg;

    localparam int GRANULE = 16;
    localparam int GRAN_SH = 4;
    localparam int CLS_W   = 5;
    localparam int HB_W    = 17;
    localparam int SIZE_W  = 9;
    localparam int ADDR_W  = 16;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_POP   = 5'b01000,
        S_FREE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic load_req;
        logic clear_step;
        logic rd_issue;
        logic exec_commit;
        logic pop_commit;
        logic free_commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic need_pop;
        logic need_free;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: design/scba_if.sv
// request, response and configuration channel interfaces
interface scba_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [8:0]  req_size;
    logic [15:0] data_addr;
    modport source (output valid, output req_type, output req_size, output data_addr,
                    input ready);
    modport sink   (input valid, input req_type, input req_size, input data_addr,
                    output ready);
endinterface

interface scba_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_addr;
    logic [1:0]  status;
    modport source (output valid, output result_addr, output status, input ready);
    modport sink   (input valid, input result_addr, input status, output ready);
endinterface

interface scba_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] heap_bytes;
    modport source (output valid, output heap_bytes, input ready);
    modport sink   (input valid, input heap_bytes, output ready);
endinterface

FILE: design/scba_ctrl.sv
// controller state machine of the allocator
module scba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  scba_pkg::t_dp_sts i_sts,
    output scba_pkg::t_dp_cmd o_cmd
);
    import scba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.need_pop) begin
                    n_state = S_POP;
                end else if (i_sts.need_free) begin
                    n_state = S_FREE;
                end else if (i_sts.out_free) begin
                    o_cmd.exec_commit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_POP: begin
                if (i_sts.out_free) begin
                    o_cmd.pop_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_FREE: begin
                if (i_sts.out_free) begin
                    o_cmd.free_commit = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: design/scba_dp.sv
// allocator datapath: class heads, link and mark memories, bump pointer, result register
module scba_dp #(
    parameter int HEAP_SIZE   = 65536,
    parameter int HEADER_SIZE = 16,
    parameter int NUM_CLASSES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scba_pkg::t_dp_cmd             i_cmd,
    output scba_pkg::t_dp_sts             o_sts,
    input  logic                          i_req_type,
    input  logic [scba_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [scba_pkg::ADDR_W-1:0]   i_data_addr,
    input  logic                          i_cfg_valid,
    input  logic [scba_pkg::HB_W-1:0]     i_cfg_heap_bytes,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [scba_pkg::ADDR_W-1:0]   o_result_addr,
    output scba_pkg::t_status             o_status
);
    import scba_pkg::*;

    localparam int NUM_GRAN = HEAP_SIZE / GRANULE;
    localparam int GW       = $clog2(NUM_GRAN);
    localparam int CI_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    typedef struct packed {
        logic          empty;
        logic [GW-1:0] idx;
    } t_head;

    logic              r_type;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [HB_W-1:0]   r_heap_bytes;
    logic [HB_W-1:0]   r_bump;
    logic [HB_W-1:0]   n_bump;
    logic [GW-1:0]     r_clr;
    t_head             r_heads [NUM_CLASSES];
    logic [CLS_W-1:0]  r_marks [NUM_GRAN];
    t_head             r_links [NUM_GRAN];
    logic [CLS_W-1:0]  r_mark_rd;
    t_head             r_link_rd;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_result_addr;
    t_status           r_status;
    logic [ADDR_W-1:0] n_result_addr;
    t_status           n_status;

    logic [CLS_W:0]    cls_raw;
    logic [CLS_W-1:0]  cls;
    logic              oversize;
    logic [CI_W-1:0]   cidx;
    t_head             head;
    logic [HB_W-1:0]   limit;
    logic [HB_W:0]     total;
    logic              fits;
    logic              carve_in;
    logic [ADDR_W-1:0] hoff;
    logic              addr_ok;
    logic [GW-1:0]     h_free;
    logic              mark_ok;
    logic [CI_W-1:0]   fidx;
    logic              commit;
    logic              carve_wr;
    logic              mk_wr;
    logic [GW-1:0]     mk_addr;
    logic [CLS_W-1:0]  mk_data;

    // request decode
    always_comb begin
        cls_raw  = (CLS_W + 1)'(({1'b0, r_size} + 10'(GRANULE - 1)) >> GRAN_SH);
        cls      = (cls_raw == '0) ? CLS_W'(1) : CLS_W'(cls_raw);
        oversize = 32'(cls_raw) > NUM_CLASSES;
        cidx     = CI_W'(cls - CLS_W'(1));
        head     = r_heads[cidx];
        limit    = (32'(r_heap_bytes) > HEAP_SIZE) ? HB_W'(HEAP_SIZE) : r_heap_bytes;
        total    = ((HB_W + 1)'(cls) << GRAN_SH) + (HB_W + 1)'(HEADER_SIZE);
        fits     = ({1'b0, r_bump} + total) <= {1'b0, limit};
        carve_in = 32'(r_bump[HB_W-1:GRAN_SH]) < NUM_GRAN;
        hoff     = r_addr - ADDR_W'(HEADER_SIZE);
        addr_ok  = (32'(r_addr) >= HEADER_SIZE) && (hoff[GRAN_SH-1:0] == '0)
                   && (32'(hoff[ADDR_W-1:GRAN_SH]) < NUM_GRAN);
        h_free   = GW'(hoff[ADDR_W-1:GRAN_SH]);
        mark_ok  = (r_mark_rd != '0) && (32'(r_mark_rd) <= NUM_CLASSES);
        fidx     = CI_W'(r_mark_rd - CLS_W'(1));
    end

    assign o_sts.clear_last = (r_clr == GW'(NUM_GRAN - 1));
    assign o_sts.need_pop   = (r_type == REQ_ALLOC) && !oversize && !head.empty;
    assign o_sts.need_free  = (r_type == REQ_FREE) && addr_ok;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign commit   = i_cmd.exec_commit || i_cmd.pop_commit || i_cmd.free_commit;
    assign carve_wr = i_cmd.exec_commit && (r_type == REQ_ALLOC) && !oversize && fits;

    // result and bump pointer
    always_comb begin
        n_result_addr = '0;
        n_status      = ST_OK;
        n_bump        = r_bump;
        if (i_cmd.exec_commit) begin
            if (r_type == REQ_FREE) begin
                n_status = ST_BAD_FREE;
            end else if (oversize) begin
                n_status = ST_TOO_LARGE;
            end else if (!fits) begin
                n_status = ST_EXHAUSTED;
            end else begin
                n_result_addr = ADDR_W'((32'(r_bump[HB_W-1:GRAN_SH]) << GRAN_SH) + HEADER_SIZE);
                n_bump        = HB_W'({1'b0, r_bump} + total);
            end
        end else if (i_cmd.pop_commit) begin
            n_result_addr = ADDR_W'((32'(head.idx) << GRAN_SH) + HEADER_SIZE);
        end else if (i_cmd.free_commit) begin
            n_status = mark_ok ? ST_OK : ST_BAD_FREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_type <= i_req_type;
            r_size <= i_req_size;
            r_addr <= i_data_addr;
        end
        if (commit) begin
            r_result_addr <= n_result_addr;
            r_status      <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_bytes <= HB_W'(65536);
            r_bump       <= '0;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_heads[i] <= '{empty: 1'b1, idx: '0};
            end
        end else begin
            if (i_cfg_valid) begin
                r_heap_bytes <= i_cfg_heap_bytes;
            end
            r_bump <= n_bump;
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + GW'(1);
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.pop_commit) begin
                r_heads[cidx] <= r_link_rd;
            end else if (i_cmd.free_commit && mark_ok) begin
                r_heads[fidx] <= '{empty: 1'b0, idx: h_free};
            end
        end
    end

    // mark memory: clearing pass after reset, class written on carve
    always_comb begin
        mk_wr   = i_cmd.clear_step || (carve_wr && carve_in);
        mk_addr = i_cmd.clear_step ? r_clr : GW'(r_bump[HB_W-1:GRAN_SH]);
        mk_data = i_cmd.clear_step ? '0 : cls;
    end

    always_ff @(posedge i_clk) begin
        if (mk_wr) begin
            r_marks[mk_addr] <= mk_data;
        end
        if (i_cmd.rd_issue) begin
            r_mark_rd <= r_marks[h_free];
        end
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.free_commit && mark_ok) begin
            r_links[h_free] <= r_heads[fidx];
        end
        if (i_cmd.rd_issue) begin
            r_link_rd <= r_links[head.idx];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_addr = r_result_addr;
    assign o_status      = r_status;

    a_bump_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_bump >= $past(r_bump)))
        else $error("bump pointer moved backward");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("committed beat not presented");

    a_single_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.exec_commit, i_cmd.pop_commit, i_cmd.free_commit, i_cmd.load_req}))
        else $error("overlapping datapath commands");

    a_no_commit_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_out_valid) |-> i_out_ready)
        else $error("result overwritten before taken");

endmodule

FILE: design/size_class_block_allocator_core.sv
// top level of the size class block allocator
//
// i_req carries allocate or free beats; o_rsp returns one beat per request with
// the data offset and a status. i_cfg writes the usable heap size in bytes and
// is always ready; write it only while no request is outstanding.
// After reset the mark store is swept clear, one entry per cycle, over all
// HEAP_SIZE/16 entries (4096 by default); i_req is not ready during the sweep.
// A request is taken in one cycle and evaluated in the next. Oversize requests,
// exhausted allocations, frees of an address off the granule grid or outside
// the heap and carves from the bump pointer commit from the evaluating state.
// A pop from a class list or a free of an in-range address first needs a
// registered read of the link or mark memory, then commits from the POP or FREE state.
// The result sits in an output register; i_req is ready again while it waits.
// When o_rsp stalls, a finished request holds in the controller until the
// output register empties, and no further beat is taken until then.
module size_class_block_allocator_core #(
    parameter int HEAP_SIZE   = 65536,
    parameter int HEADER_SIZE = 16,
    parameter int NUM_CLASSES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scba_req_if.sink          i_req,
    scba_rsp_if.source        o_rsp,
    scba_cfg_if.sink          i_cfg
);
    import scba_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_status status;

    assign i_cfg.ready = 1'b1;

    scba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    scba_dp #(
        .HEAP_SIZE   (HEAP_SIZE),
        .HEADER_SIZE (HEADER_SIZE),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_req_type       (i_req.req_type),
        .i_req_size       (i_req.req_size),
        .i_data_addr      (i_req.data_addr),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_heap_bytes (i_cfg.heap_bytes),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_result_addr    (o_rsp.result_addr),
        .o_status         (status)
    );

    assign o_rsp.status = status;

endmodule
